/* sv/rsid_pkg.sv */
// ----------------------------------------------------------------------------
// rsid_pkg : shared types and constants of the ranked set unit
// Sizes of the cell chain and the reduction tree, request and status codes,
// and the command word that is broadcast along the chain.
// ----------------------------------------------------------------------------
package rsid_pkg;

   localparam int CAPACITY  = 1024;
   localparam int KEY_BITS  = 32;
   localparam int KEY_IN_W  = 32;                     // width of the key port
   localparam int POS_W     = 10;                     // width of the position port
   localparam int IDX_W     = $clog2(CAPACITY);       // cell index
   localparam int RANK_W    = $clog2(CAPACITY + 1);   // rank and fill count
   localparam int CMP_W     = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam int GRP_SIZE  = 32;
   localparam int GRP_CNT   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   typedef logic signed [KEY_BITS-1:0] key_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // broadcast to every cell
   typedef struct packed {
      op_type           op;
      key_type          key;
      logic [POS_W-1:0] pos;
      logic             cmp_en;
      logic             upd_en;
   } cell_cmd_type;

endpackage

/* sv/rsid_cell.sv */
// ----------------------------------------------------------------------------
// rsid_cell : one place of the sorted chain
// Holds one key, compares it with the broadcast word and, on update, takes the
// request key or the upper or lower neighbour's key to open or close a gap.
// ----------------------------------------------------------------------------
module rsid_cell (
   input  logic                       clock,
   input  rsid_pkg::cell_cmd_type     cmd,
   input  logic [rsid_pkg::RANK_W-1:0] occ,
   input  logic [rsid_pkg::IDX_W-1:0]  cell_idx,
   input  logic                       prev_keep,
   input  rsid_pkg::key_type          prev_key,
   input  rsid_pkg::key_type          next_key,
   output rsid_pkg::key_type          key_out,
   output logic                       keep_out,
   output logic                       bnd_out,
   output logic                       hit_out
);
   import rsid_pkg::*;

   key_type key_ff;
   key_type key_in;
   logic    keep_ff;
   logic    keep_in;
   logic    hit_ff;
   logic    hit_in;
   logic    occupied;
   logic    at_pos;

   assign occupied = RANK_W'(cell_idx) < occ;
   assign at_pos   = CMP_W'(cell_idx) == CMP_W'(cmd.pos);

   // keep: this cell stays put on update
   always_comb begin
      if (cmd.op == OP_INSERT) begin
         keep_in = occupied && (key_ff > cmd.key);
         hit_in  = occupied && (key_ff == cmd.key);
         key_in  = prev_keep ? cmd.key : prev_key;
      end else begin
         keep_in = CMP_W'(cell_idx) < CMP_W'(cmd.pos);
         hit_in  = occupied && at_pos;
         key_in  = next_key;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_en) begin
         keep_ff <= keep_in;
         hit_ff  <= hit_in;
      end
      if (cmd.upd_en && !keep_ff) begin
         key_ff <= key_in;
      end
   end

   assign key_out  = key_ff;
   assign keep_out = keep_ff;
   assign bnd_out  = prev_keep && !keep_ff;  // first cell not kept: on insert, first not above the key
   assign hit_out  = hit_ff;

endmodule

/* sv/rsid_reduce.sv */
// ----------------------------------------------------------------------------
// rsid_reduce : two-stage registered OR tree over the chain
// Encodes the single boundary cell into its index and merges the hit flags.
// The group results and the merged result are each registered.
// ----------------------------------------------------------------------------
module rsid_reduce (
   input  logic                          clock,
   input  logic [rsid_pkg::CAPACITY-1:0] bnd,
   input  logic [rsid_pkg::CAPACITY-1:0] hit,
   output logic [rsid_pkg::IDX_W-1:0]    idx_out,
   output logic                          hit_out
);
   import rsid_pkg::*;

   logic [IDX_W-1:0] grp_idx_ff [GRP_CNT];
   logic [IDX_W-1:0] grp_idx_in [GRP_CNT];
   logic             grp_hit_ff [GRP_CNT];
   logic             grp_hit_in [GRP_CNT];
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             hit_ff;
   logic             hit_in;

   always_comb begin
      for (int g = 0; g < GRP_CNT; g++) begin
         grp_idx_in[g] = '0;
         grp_hit_in[g] = 1'b0;
         for (int j = 0; j < GRP_SIZE; j++) begin
            if (g * GRP_SIZE + j < CAPACITY) begin
               if (bnd[g * GRP_SIZE + j]) begin
                  grp_idx_in[g] = grp_idx_in[g] | IDX_W'(g * GRP_SIZE + j);
               end
               grp_hit_in[g] = grp_hit_in[g] | hit[g * GRP_SIZE + j];
            end
         end
      end
   end

   always_comb begin
      idx_in = '0;
      hit_in = 1'b0;
      for (int g = 0; g < GRP_CNT; g++) begin
         idx_in = idx_in | grp_idx_ff[g];
         hit_in = hit_in | grp_hit_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GRP_CNT; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
         grp_hit_ff[g] <= grp_hit_in[g];
      end
      idx_ff <= idx_in;
      hit_ff <= hit_in;
   end

   assign idx_out = idx_ff;
   assign hit_out = hit_ff;

endmodule

/* sv/ranked_set_insert_delete_unit.sv */
// ----------------------------------------------------------------------------
// ranked_set_insert_delete_unit : sorted set of distinct signed keys
// Insert returns the count of greater keys, delete removes by descending
// position; built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One request word is taken at a time, in the idle state. It then passes
// through the compare state, in which every cell compares its key with the
// request, the states S_RED1 and S_RED2 of the registered OR tree that finds
// the insertion point and the duplicate or position hit across all cells,
// and the update state, in which the whole chain shifts at once. The result
// is registered at the end of the update state, and the next word can be
// taken once the unit is back in the idle state. The result sits in an
// output register; a new request may be accepted while it waits, but its
// update is held back until the previous result has been taken. The key
// store needs no clearing after reset: only the first fill-count cells are
// ever looked at.
// ----------------------------------------------------------------------------
module ranked_set_insert_delete_unit (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic signed [rsid_pkg::KEY_IN_W-1:0] req_key,
   input  logic [rsid_pkg::POS_W-1:0]  req_position,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rsid_pkg::RANK_W-1:0] rsp_rank,
   output logic [1:0]                  rsp_status
);
   import rsid_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMP  = 5'b00010,
      S_RED1 = 5'b00100,
      S_RED2 = 5'b01000,
      S_UPD  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [RANK_W-1:0]  occ_ff, occ_in;
   op_type             op_ff;
   key_type            key_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   status_type         rsp_status_ff, rsp_status_in;

   cell_cmd_type       cmd;
   key_type            key_w  [CAPACITY];
   logic [CAPACITY-1:0] keep_w;
   logic [CAPACITY-1:0] bnd_w;
   logic [CAPACITY-1:0] hit_w;
   logic [IDX_W-1:0]   red_idx;
   logic               red_hit;

   logic               accept;
   logic               go;        // output register free for a new word
   logic               change;    // store is altered by this request

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign go        = !(rsp_valid_ff && rsp_stall);

   // request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_type);
         key_ff <= key_type'(req_key);
         pos_ff <= req_position;
      end
   end

   // --- decision at the end of the reduction ---
   always_comb begin
      rsp_rank_in   = '0;
      rsp_status_in = STAT_OK;
      change        = 1'b0;
      occ_in        = occ_ff;
      if (op_ff == OP_INSERT) begin
         if (red_hit) begin
            rsp_status_in = STAT_DUP;
            rsp_rank_in   = RANK_W'(red_idx);
         end else if (occ_ff == RANK_W'(CAPACITY)) begin
            rsp_status_in = STAT_FULL;
         end else begin
            rsp_rank_in = RANK_W'(red_idx);
            change      = 1'b1;
            occ_in      = occ_ff + RANK_W'(1);
         end
      end else begin
         if (red_hit) begin
            change = 1'b1;
            occ_in = occ_ff - RANK_W'(1);
         end else begin
            rsp_status_in = STAT_RANGE;
         end
      end
   end

   assign cmd.op     = op_ff;
   assign cmd.key    = key_ff;
   assign cmd.pos    = pos_ff;
   assign cmd.cmp_en = (state_ff == S_CMP);
   assign cmd.upd_en = (state_ff == S_UPD) && go && change;

   // --- sequencer ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_CMP;
         end
         S_CMP:  state_in = S_RED1;
         S_RED1: state_in = S_RED2;
         S_RED2: state_in = S_UPD;
         S_UPD: begin
            if (go) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == S_UPD && go) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_UPD && go) occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_UPD && go) begin
         rsp_rank_ff   <= rsp_rank_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rank   = rsp_rank_ff;
   assign rsp_status = rsp_status_ff;

   // --- cell chain, position 0 holds the greatest key ---
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic    prev_keep;
      key_type prev_key;
      key_type next_key;

      if (i == 0) begin : g_head
         assign prev_keep = 1'b1;
         assign prev_key  = key_ff;
      end else begin : g_body
         assign prev_keep = keep_w[i-1];
         assign prev_key  = key_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_key = key_w[i];
      end else begin : g_mid
         assign next_key = key_w[i+1];
      end

      rsid_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occ       (occ_ff),
         .cell_idx  (IDX_W'(i)),
         .prev_keep (prev_keep),
         .prev_key  (prev_key),
         .next_key  (next_key),
         .key_out   (key_w[i]),
         .keep_out  (keep_w[i]),
         .bnd_out   (bnd_w[i]),
         .hit_out   (hit_w[i])
      );
   end

   rsid_reduce u_reduce (
      .clock   (clock),
      .bnd     (bnd_w),
      .hit     (hit_w),
      .idx_out (red_idx),
      .hit_out (red_hit)
   );

   // --- checks ---
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= RANK_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_occ_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_UPD) |=> $stable(occ_ff))
      else $error("fill count moved outside the update cycle");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPD))
      else $error("response raised without an update");

   a_dup_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_DUP) |-> (rsp_rank_ff < occ_ff))
      else $error("duplicate rank not below fill count");

   a_refused_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_FULL || rsp_status_ff == STAT_RANGE))
      |-> (rsp_rank_ff == '0))
      else $error("refused request with non-zero rank");

endmodule
